// ----- design/jpeg_huffman_bit_reader_defines.svh -----
// ----------------------------------------------------------------------------
// jpeg huffman bit reader assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef JPEG_HUFFMAN_BIT_READER_DEFINES_SVH
`define JPEG_HUFFMAN_BIT_READER_DEFINES_SVH

// same-cycle implication
`define JHBR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jhbr check failed");

// next-cycle implication
`define JHBR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jhbr check failed");

`endif

// ----- design/jhbr_pkg.sv -----
// ----------------------------------------------------------------------------
// jhbr_pkg
// types and codes shared by the jpeg huffman bit reader files
// ----------------------------------------------------------------------------
package jhbr_pkg;

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_STREAM = 2'd1;
   localparam logic [1:0] MODE_DECODE = 2'd2;
   localparam logic [1:0] MODE_RAW    = 2'd3;

   localparam logic [2:0] TGT_MIN   = 3'd0;
   localparam logic [2:0] TGT_MAX   = 3'd1;
   localparam logic [2:0] TGT_START = 3'd2;
   localparam logic [2:0] TGT_SYM   = 3'd3;
   localparam logic [2:0] TGT_COUNT = 3'd4;

   localparam logic [2:0] KIND_SYMBOL  = 3'd0;
   localparam logic [2:0] KIND_RAW     = 3'd1;
   localparam logic [2:0] KIND_RESTART = 3'd2;
   localparam logic [2:0] KIND_BAD     = 3'd3;
   localparam logic [2:0] KIND_PROTO   = 3'd4;

   localparam logic [7:0]  MARKER_BYTE = 8'hFF;
   localparam logic [7:0]  RST_LO      = 8'hD0;
   localparam logic [7:0]  RST_HI      = 8'hD7;
   localparam logic [15:0] CODE_HALF   = 16'h8000;
   localparam logic [4:0]  MAX_RAW     = 5'd16;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  table_id;
      logic [2:0]  load_target;
      logic [7:0]  load_index;
      logic [15:0] load_value;
      logic [7:0]  stream_byte;
      logic [4:0]  bit_count;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [15:0] result_value;
      logic [4:0]  code_length;
   } rsp_type;

   typedef struct packed {
      logic restart;
      logic overflow;
      logic pushed;
      logic bit_avail;
      logic bit_value;
   } src_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_STEP,
      ST_SYM,
      ST_SYM_OUT
   } state_type;

endpackage

// ----- design/jpeg_huffman_bit_reader.sv -----
// ----------------------------------------------------------------------------
// jpeg_huffman_bit_reader
// entropy-segment bit reader with huffman symbol and raw-bit requests
// ----------------------------------------------------------------------------
// usage:
//   req channel carries table loads, stream bytes, decode and raw-bit requests
//   rsp channel carries at most one result per request transfer
//   a table load gives no result
//   a stream byte is destuffed and queued; restart markers and
//   queue overflow answer at once
//   a pending request consumes one bit per step: ST_FETCH reads the
//   per-length min/max/start memories, ST_STEP compares the grown code
//   a decoded symbol adds ST_SYM and ST_SYM_OUT for the symbol memory read
//   a request waits (req_stall low again) once the bit buffer runs dry; the
//   next queued stream byte resumes it
//   req_stall is high while the sequencer works or a result sits in the
//   output register
//   when rsp_stall is high the result register holds its value and no new
//   transfer is taken on req
//   reset clears the queue, the bit buffer, pending request and symbol counts;
//   table memories are not cleared and need loading before use
// ----------------------------------------------------------------------------
module jpeg_huffman_bit_reader #(
   parameter int NUM_TABLES        = 4,
   parameter int MAX_CODE_LEN      = 16,
   parameter int SYMBOLS_PER_TABLE = 256,
   parameter int FIFO_DEPTH        = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  jhbr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output jhbr_pkg::rsp_type rsp_data
);

   // table geometry
   localparam int KD = NUM_TABLES * MAX_CODE_LEN;
   localparam int KW = $clog2(KD);
   localparam int SD = NUM_TABLES * SYMBOLS_PER_TABLE;
   localparam int SW = $clog2(SD);
   localparam int IW = $clog2(SYMBOLS_PER_TABLE);
   localparam int CW = $clog2(SYMBOLS_PER_TABLE + 1);
   localparam int TW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;

   // table memories
   logic [15:0] min_mem   [KD];
   logic [15:0] max_mem   [KD];
   logic [7:0]  start_mem [KD];
   logic [7:0]  sym_mem   [SD];
   logic [CW-1:0] count_ff [NUM_TABLES];

   logic [15:0] min_rd_ff, max_rd_ff;
   logic [7:0]  start_rd_ff, sym_rd_ff;

   // sequencer and request state
   jhbr_pkg::state_type state_ff, state_in;
   logic        pending_ff, pending_in;
   logic        is_raw_ff, is_raw_in;
   logic [1:0]  table_ff, table_in;
   logic [4:0]  wanted_ff, wanted_in;
   logic [15:0] code_ff, code_in;
   logic [4:0]  length_ff, length_in;
   logic [IW-1:0] idx_ff, idx_in;

   // result register
   logic              rsp_valid_ff;
   jhbr_pkg::rsp_type rsp_ff;
   logic              emit;
   jhbr_pkg::rsp_type emit_data;

   // bit source hookup
   logic                     src_byte_valid, src_take_bit;
   jhbr_pkg::src_status_type src_status;

   logic        accept;
   logic        load_table_ok;
   logic [KW-1:0] kaddr, load_kaddr;
   logic [SW-1:0] saddr, load_saddr;
   logic [15:0] new_code;
   logic [4:0]  new_length;
   logic        match;
   logic [16:0] idx_full;
   logic [CW-1:0] count_sel;

   jhbr_bit_source #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_src (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (src_byte_valid),
      .byte_data  (req_data.stream_byte),
      .take_bit   (src_take_bit),
      .status_out (src_status)
   );

   assign req_stall = (state_ff != jhbr_pkg::ST_IDLE) || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;

   assign load_table_ok = (32'(req_data.table_id) < NUM_TABLES);
   assign load_kaddr    = KW'(req_data.table_id * MAX_CODE_LEN + req_data.load_index);
   assign load_saddr    = SW'(req_data.table_id * SYMBOLS_PER_TABLE + req_data.load_index);
   assign kaddr         = KW'(table_ff * MAX_CODE_LEN + length_ff);
   assign saddr         = SW'(table_ff * SYMBOLS_PER_TABLE + idx_ff);

   // code grows by one bit per step
   assign new_code   = {code_ff[14:0], src_status.bit_value};
   assign new_length = length_ff + 5'd1;
   assign count_sel  = count_ff[TW'(table_ff)];
   assign match      = (new_code <= max_rd_ff) &&
                       ((max_rd_ff >= jhbr_pkg::CODE_HALF) || (min_rd_ff <= jhbr_pkg::CODE_HALF));
   assign idx_full   = {1'b0, new_code - min_rd_ff} + {9'd0, start_rd_ff};

   // next state and outputs
   always_comb begin
      state_in       = state_ff;
      pending_in     = pending_ff;
      is_raw_in      = is_raw_ff;
      table_in       = table_ff;
      wanted_in      = wanted_ff;
      code_in        = code_ff;
      length_in      = length_ff;
      idx_in         = idx_ff;
      src_byte_valid = 1'b0;
      src_take_bit   = 1'b0;
      emit           = 1'b0;
      emit_data      = '0;
      unique case (state_ff)
         jhbr_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.mode) inside
                  jhbr_pkg::MODE_LOAD: begin
                  end
                  jhbr_pkg::MODE_STREAM: begin
                     src_byte_valid = 1'b1;
                     if (src_status.restart) begin
                        emit                  = 1'b1;
                        emit_data.result_kind = jhbr_pkg::KIND_RESTART;
                     end else if (src_status.overflow) begin
                        emit                  = 1'b1;
                        emit_data.result_kind = jhbr_pkg::KIND_PROTO;
                     end else if (src_status.pushed && pending_ff) begin
                        state_in = jhbr_pkg::ST_FETCH;
                     end
                  end
                  jhbr_pkg::MODE_DECODE, jhbr_pkg::MODE_RAW: begin
                     if (pending_ff) begin
                        emit                  = 1'b1;
                        emit_data.result_kind = jhbr_pkg::KIND_PROTO;
                     end else if (req_data.mode == jhbr_pkg::MODE_RAW &&
                                  req_data.bit_count > jhbr_pkg::MAX_RAW) begin
                        emit                  = 1'b1;
                        emit_data.result_kind = jhbr_pkg::KIND_PROTO;
                     end else if (req_data.mode == jhbr_pkg::MODE_RAW &&
                                  req_data.bit_count == 5'd0) begin
                        emit                  = 1'b1;
                        emit_data.result_kind = jhbr_pkg::KIND_RAW;
                     end else if (req_data.mode == jhbr_pkg::MODE_DECODE &&
                                  !load_table_ok) begin
                        emit                  = 1'b1;
                        emit_data.result_kind = jhbr_pkg::KIND_PROTO;
                     end else begin
                        pending_in = 1'b1;
                        is_raw_in  = (req_data.mode == jhbr_pkg::MODE_RAW);
                        wanted_in  = (req_data.mode == jhbr_pkg::MODE_RAW) ?
                                     req_data.bit_count : 5'd0;
                        table_in   = req_data.table_id;
                        code_in    = '0;
                        length_in  = '0;
                        state_in   = jhbr_pkg::ST_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         jhbr_pkg::ST_FETCH: begin
            // per-length bounds are read here
            state_in = jhbr_pkg::ST_STEP;
         end
         jhbr_pkg::ST_STEP: begin
            if (!src_status.bit_avail) begin
               // buffer ran dry, request stays pending
               state_in = jhbr_pkg::ST_IDLE;
            end else begin
               src_take_bit = 1'b1;
               code_in      = new_code;
               length_in    = new_length;
               state_in     = jhbr_pkg::ST_FETCH;
               if (is_raw_ff) begin
                  wanted_in = wanted_ff - 5'd1;
                  if (wanted_ff == 5'd1) begin
                     pending_in             = 1'b0;
                     emit                   = 1'b1;
                     emit_data.result_kind  = jhbr_pkg::KIND_RAW;
                     emit_data.result_value = new_code;
                     state_in               = jhbr_pkg::ST_IDLE;
                  end
               end else if (match) begin
                  pending_in = 1'b0;
                  if (idx_full >= 17'(count_sel)) begin
                     emit                  = 1'b1;
                     emit_data.result_kind = jhbr_pkg::KIND_BAD;
                     emit_data.code_length = new_length;
                     state_in              = jhbr_pkg::ST_IDLE;
                  end else begin
                     idx_in   = idx_full[IW-1:0];
                     state_in = jhbr_pkg::ST_SYM;
                  end
               end else if (new_length >= 5'(MAX_CODE_LEN)) begin
                  // code too long
                  pending_in            = 1'b0;
                  emit                  = 1'b1;
                  emit_data.result_kind = jhbr_pkg::KIND_BAD;
                  emit_data.code_length = new_length;
                  state_in              = jhbr_pkg::ST_IDLE;
               end
            end
         end
         jhbr_pkg::ST_SYM: begin
            // symbol memory read
            state_in = jhbr_pkg::ST_SYM_OUT;
         end
         jhbr_pkg::ST_SYM_OUT: begin
            emit                   = 1'b1;
            emit_data.result_kind  = jhbr_pkg::KIND_SYMBOL;
            emit_data.result_value = {8'd0, sym_rd_ff};
            emit_data.code_length  = length_ff;
            state_in               = jhbr_pkg::ST_IDLE;
         end
         default: begin
            state_in = jhbr_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jhbr_pkg::ST_IDLE;
         pending_ff   <= 1'b0;
         is_raw_ff    <= 1'b0;
         table_ff     <= '0;
         wanted_ff    <= '0;
         code_ff      <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         is_raw_ff  <= is_raw_in;
         table_ff   <= table_in;
         wanted_ff  <= wanted_in;
         code_ff    <= code_in;
         length_ff  <= length_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (emit) begin
         rsp_ff <= emit_data;
      end
   end

   // symbol counts, saturated on load
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TABLES; i++) begin
            count_ff[i] <= '0;
         end
      end else if (accept && req_data.mode == jhbr_pkg::MODE_LOAD && load_table_ok &&
                   req_data.load_target == jhbr_pkg::TGT_COUNT) begin
         count_ff[TW'(req_data.table_id)] <=
            (32'(req_data.load_value) > SYMBOLS_PER_TABLE) ?
            CW'(SYMBOLS_PER_TABLE) : CW'(req_data.load_value);
      end
   end

   // per-length bound memories
   always_ff @(posedge clock) begin
      if (accept && req_data.mode == jhbr_pkg::MODE_LOAD && load_table_ok &&
          32'(req_data.load_index) < MAX_CODE_LEN) begin
         case (req_data.load_target)
            jhbr_pkg::TGT_MIN:   min_mem[load_kaddr]   <= req_data.load_value;
            jhbr_pkg::TGT_MAX:   max_mem[load_kaddr]   <= req_data.load_value;
            jhbr_pkg::TGT_START: start_mem[load_kaddr] <= req_data.load_value[7:0];
            default: begin
            end
         endcase
      end
      if (state_ff == jhbr_pkg::ST_FETCH) begin
         min_rd_ff   <= min_mem[kaddr];
         max_rd_ff   <= max_mem[kaddr];
         start_rd_ff <= start_mem[kaddr];
      end
   end

   // symbol value memory
   always_ff @(posedge clock) begin
      if (accept && req_data.mode == jhbr_pkg::MODE_LOAD && load_table_ok &&
          req_data.load_target == jhbr_pkg::TGT_SYM &&
          32'(req_data.load_index) < SYMBOLS_PER_TABLE) begin
         sym_mem[load_saddr] <= req_data.load_value[7:0];
      end
      if (state_ff == jhbr_pkg::ST_SYM) begin
         sym_rd_ff <= sym_mem[saddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/jhbr_bit_source.sv -----
// ----------------------------------------------------------------------------
// jhbr_bit_source
// byte destuffing, byte queue and msb-first bit buffer
// ----------------------------------------------------------------------------
module jhbr_bit_source #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         byte_valid,
   input  logic [7:0]                   byte_data,
   input  logic                         take_bit,
   output jhbr_pkg::src_status_type     status_out
);

   localparam int CNTW = $clog2(FIFO_DEPTH + 1);
   localparam int FW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

   logic [7:0]      fifo_ff [FIFO_DEPTH];
   logic [CNTW-1:0] count_ff, count_in;
   logic [7:0]      cur_ff, cur_in;
   logic [3:0]      left_ff, left_in;
   logic            marker_ff, marker_in;
   logic            want_push, do_push, do_pop, restart, full;
   logic [7:0]      push_val;

   assign full = (count_ff == CNTW'(FIFO_DEPTH));

   always_comb begin
      want_push = 1'b0;
      restart   = 1'b0;
      push_val  = byte_data;
      marker_in = marker_ff;
      if (byte_valid) begin
         if (marker_ff) begin
            marker_in = 1'b0;
            restart   = (byte_data >= jhbr_pkg::RST_LO) && (byte_data <= jhbr_pkg::RST_HI);
            want_push = !restart;
            push_val  = (byte_data == 8'd0) ? jhbr_pkg::MARKER_BYTE : byte_data;
         end else if (byte_data == jhbr_pkg::MARKER_BYTE) begin
            marker_in = 1'b1;
         end else begin
            want_push = 1'b1;
         end
      end
   end

   assign do_push = want_push && !full;
   assign do_pop  = take_bit && (left_ff == 4'd0) && !byte_valid;

   always_comb begin
      count_in = count_ff;
      cur_in   = cur_ff;
      left_in  = left_ff;
      if (do_push) begin
         count_in = count_ff + CNTW'(1);
      end else if (take_bit && !byte_valid) begin
         if (left_ff == 4'd0) begin
            cur_in   = {fifo_ff[0][6:0], 1'b0};
            left_in  = 4'd7;
            count_in = count_ff - CNTW'(1);
         end else begin
            cur_in  = {cur_ff[6:0], 1'b0};
            left_in = left_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cur_ff    <= '0;
         left_ff   <= '0;
         marker_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         cur_ff    <= cur_in;
         left_ff   <= left_in;
         marker_ff <= marker_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         fifo_ff[count_ff[FW-1:0]] <= push_val;
      end else if (do_pop) begin
         for (int i = 0; i < FIFO_DEPTH - 1; i++) begin
            fifo_ff[i] <= fifo_ff[i+1];
         end
      end
   end

   assign status_out.restart   = restart;
   assign status_out.overflow  = want_push && full;
   assign status_out.pushed    = do_push;
   assign status_out.bit_avail = (left_ff != 4'd0) || (count_ff != '0);
   assign status_out.bit_value = (left_ff != 4'd0) ? cur_ff[7] : fifo_ff[0][7];

endmodule

// ----- design/jhbr_checker.sv -----
// ----------------------------------------------------------------------------
// jhbr_checker
// port-level checks for the jpeg huffman bit reader
// ----------------------------------------------------------------------------
`include "jpeg_huffman_bit_reader_defines.svh"

module jhbr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input jhbr_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input jhbr_pkg::rsp_type rsp_data
);

   `JHBR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   `JHBR_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

   `JHBR_ASSERT_NOW(a_other_zero, clock, reset, rsp_valid && (rsp_data.result_kind == jhbr_pkg::KIND_RESTART || rsp_data.result_kind == jhbr_pkg::KIND_PROTO), rsp_data.result_value == 16'd0 && rsp_data.code_length == 5'd0)

   `JHBR_ASSERT_NOW(a_symbol_shape, clock, reset, rsp_valid && rsp_data.result_kind == jhbr_pkg::KIND_SYMBOL, rsp_data.result_value[15:8] == 8'd0 && rsp_data.code_length != 5'd0)

   // a decode or raw-bit request transfer always raises req_stall
   `JHBR_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && !req_stall && (req_data.mode == jhbr_pkg::MODE_DECODE || req_data.mode == jhbr_pkg::MODE_RAW), req_stall)

endmodule

bind jpeg_huffman_bit_reader jhbr_checker u_jhbr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the jpeg huffman bit reader: table loads, stuffed
// byte streams, symbol decodes and raw-bit reads are predicted in a local
// model of the reader and every result transfer is compared field by field
// ----------------------------------------------------------------------------

class decode_scoreboard;
   jhbr_pkg::rsp_type pending_results[$];
   int unsigned mismatch_count = 0;
   int unsigned result_count = 0;

   // reader state mirror
   logic [7:0]  cur_byte;
   int          bits_in_byte;
   logic [7:0]  byte_queue[$];
   bit          saw_marker;
   bit          req_busy;
   bit          req_raw;
   logic [1:0]  req_tab;
   int          bits_wanted;
   logic [15:0] code_acc;
   int          code_len;
   logic [15:0] min_code[64];
   logic [15:0] max_code[64];
   logic [7:0]  start_idx[64];
   logic [7:0]  sym_val[1024];
   int          sym_count[4];

   function void clear();
      cur_byte = 0; bits_in_byte = 0; byte_queue.delete(); saw_marker = 0;
      req_busy = 0; req_raw = 0; req_tab = 0; bits_wanted = 0;
      code_acc = 0; code_len = 0;
      foreach (sym_count[i]) sym_count[i] = 0;
   endfunction

   function void add_result(logic [2:0] kind, logic [15:0] value, int len);
      jhbr_pkg::rsp_type r;
      r.result_kind = kind; r.result_value = value; r.code_length = len[4:0];
      pending_results.push_back(r);
   endfunction

   // run the pending request as far as the buffered bits allow
   function void consume_bits();
      int k;
      logic [16:0] idx;
      bit b;
      while (req_busy) begin
         if (bits_in_byte == 0) begin
            if (byte_queue.size() == 0) return;
            cur_byte = byte_queue.pop_front();
            bits_in_byte = 8;
         end
         bits_in_byte--;
         b = cur_byte[bits_in_byte];
         code_acc = {code_acc[14:0], b};
         code_len++;
         if (req_raw) begin
            bits_wanted--;
            if (bits_wanted == 0) begin
               req_busy = 0;
               add_result(jhbr_pkg::KIND_RAW, code_acc, 0);
            end
         end else begin
            k = req_tab * 16 + code_len - 1;
            if (code_acc <= max_code[k] &&
                (max_code[k] >= jhbr_pkg::CODE_HALF || min_code[k] <= jhbr_pkg::CODE_HALF))
            begin
               idx = {1'b0, code_acc - min_code[k]} + start_idx[k];
               req_busy = 0;
               if (idx >= sym_count[req_tab])
                  add_result(jhbr_pkg::KIND_BAD, 0, code_len);
               else
                  add_result(jhbr_pkg::KIND_SYMBOL, sym_val[req_tab * 256 + idx], code_len);
            end else if (code_len >= 16) begin
               req_busy = 0;
               add_result(jhbr_pkg::KIND_BAD, 0, code_len);
            end
         end
      end
   endfunction

   function void push_stream(logic [7:0] b);
      if (byte_queue.size() >= 4) begin
         add_result(jhbr_pkg::KIND_PROTO, 0, 0);
         return;
      end
      byte_queue.push_back(b);
      consume_bits();
   endfunction

   function void note_transfer(jhbr_pkg::req_type q);
      case (q.mode)
         jhbr_pkg::MODE_LOAD: begin
            if (q.load_target <= jhbr_pkg::TGT_START) begin
               if (q.load_index < 16) begin
                  if (q.load_target == jhbr_pkg::TGT_MIN)
                     min_code[q.table_id * 16 + q.load_index] = q.load_value;
                  else if (q.load_target == jhbr_pkg::TGT_MAX)
                     max_code[q.table_id * 16 + q.load_index] = q.load_value;
                  else
                     start_idx[q.table_id * 16 + q.load_index] = q.load_value[7:0];
               end
            end else if (q.load_target == jhbr_pkg::TGT_SYM)
               sym_val[q.table_id * 256 + q.load_index] = q.load_value[7:0];
            else if (q.load_target == jhbr_pkg::TGT_COUNT)
               sym_count[q.table_id] = q.load_value > 256 ? 256 : q.load_value;
         end
         jhbr_pkg::MODE_STREAM: begin
            if (saw_marker) begin
               saw_marker = 0;
               if (q.stream_byte >= jhbr_pkg::RST_LO && q.stream_byte <= jhbr_pkg::RST_HI)
                  add_result(jhbr_pkg::KIND_RESTART, 0, 0);
               else
                  push_stream(q.stream_byte == 0 ? jhbr_pkg::MARKER_BYTE : q.stream_byte);
            end else if (q.stream_byte == jhbr_pkg::MARKER_BYTE)
               saw_marker = 1;
            else
               push_stream(q.stream_byte);
         end
         default: begin
            if (req_busy)
               add_result(jhbr_pkg::KIND_PROTO, 0, 0);
            else if (q.mode == jhbr_pkg::MODE_RAW && q.bit_count > jhbr_pkg::MAX_RAW)
               add_result(jhbr_pkg::KIND_PROTO, 0, 0);
            else if (q.mode == jhbr_pkg::MODE_RAW && q.bit_count == 0)
               add_result(jhbr_pkg::KIND_RAW, 0, 0);
            else begin
               req_raw = (q.mode == jhbr_pkg::MODE_RAW);
               bits_wanted = req_raw ? q.bit_count : 0;
               req_tab = q.table_id;
               req_busy = 1;
               code_acc = 0;
               code_len = 0;
               consume_bits();
            end
         end
      endcase
   endfunction

   function void check_result(jhbr_pkg::rsp_type got);
      jhbr_pkg::rsp_type want;
      result_count++;
      if (pending_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result kind %0d value %h len %0d",
                     got.result_kind, got.result_value, got.code_length);
         return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("result mismatch: expected kind %0d value %h len %0d, got %0d %h %0d",
                     want.result_kind, want.result_value, want.code_length,
                     got.result_kind, got.result_value, got.code_length);
      end
   endfunction
endclass

module tb;

   localparam int CYCLE_LIMIT = 600000;
   // symbol slots written for tables other than table 0
   localparam int SHORT_SYMS  = 32;
   localparam int RANDOM_ITEMS = 170;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   jhbr_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   jhbr_pkg::rsp_type rsp_data;

   decode_scoreboard decode_sb;

   // idling percentages, changed between phases
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   // long receiver hold-off request
   bit          hold_rsp;
   int unsigned cycle_count;
   int unsigned item_count;

   jpeg_huffman_bit_reader i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // cycle counter and timeout
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // receiver: random stall, plus a long hold-off on request
   initial begin
      int unsigned hold_cycles;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall && !reset)
            decode_sb.check_result(rsp_data);
         if (hold_rsp) begin
            // hold off for a long stretch so the block backs up
            rsp_stall <= 1'b1;
            hold_cycles = 400;
            while (hold_cycles > 0) begin
               @(posedge clock);
               hold_cycles--;
            end
            hold_rsp = 0;
            rsp_stall <= 1'b0;
         end else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // one request transfer; the valid stays high across back-to-back items
   task automatic send_item(input jhbr_pkg::req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_sb.note_transfer(q);
      item_count++;
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic jhbr_pkg::req_type blank_req(logic [1:0] mode);
      jhbr_pkg::req_type q;
      q = '0;
      q.mode = mode;
      return q;
   endfunction

   task automatic load_word(logic [1:0] t, logic [2:0] tgt, logic [7:0] ix, logic [15:0] v);
      jhbr_pkg::req_type q;
      q = blank_req(jhbr_pkg::MODE_LOAD);
      q.table_id = t; q.load_target = tgt; q.load_index = ix; q.load_value = v;
      send_item(q);
   endtask

   task automatic stream_byte(logic [7:0] b);
      jhbr_pkg::req_type q;
      q = blank_req(jhbr_pkg::MODE_STREAM);
      q.stream_byte = b;
      send_item(q);
   endtask

   task automatic ask_decode(logic [1:0] t);
      jhbr_pkg::req_type q;
      q = blank_req(jhbr_pkg::MODE_DECODE);
      q.table_id = t;
      send_item(q);
   endtask

   task automatic ask_raw(logic [4:0] n);
      jhbr_pkg::req_type q;
      q = blank_req(jhbr_pkg::MODE_RAW);
      q.bit_count = n;
      send_item(q);
   endtask

   // fill every bound entry so no decode reads an unwritten word;
   // table 0 gets all symbol slots and may saturate its count, the others
   // get a short symbol list and a count that stays inside it
   task automatic load_tables(bit sparse, bit with_syms);
      logic [15:0] lo;
      int          nsym;
      for (int t = 0; t < 4; t++) begin
         for (int l = 0; l < 16; l++) begin
            lo = 16'($urandom_range(65535) >> (15 - l));
            if (sparse && $urandom_range(2) == 0) begin
               load_word(2'(t), jhbr_pkg::TGT_MIN, 8'(l), 16'hFFFF);
               load_word(2'(t), jhbr_pkg::TGT_MAX, 8'(l), 16'h0000);
            end else begin
               load_word(2'(t), jhbr_pkg::TGT_MIN, 8'(l), lo);
               load_word(2'(t), jhbr_pkg::TGT_MAX, 8'(l), lo + 16'($urandom_range(3)));
            end
            load_word(2'(t), jhbr_pkg::TGT_START, 8'(l), 16'($urandom_range(255)));
         end
         nsym = (t == 0) ? 256 : SHORT_SYMS;
         if (with_syms) begin
            for (int s = 0; s < nsym; s++)
               load_word(2'(t), jhbr_pkg::TGT_SYM, 8'(s), 16'($urandom_range(255)));
         end
         if (t == 0)
            load_word(2'(t), jhbr_pkg::TGT_COUNT, 8'd0,
                      $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(300)));
         else
            load_word(2'(t), jhbr_pkg::TGT_COUNT, 8'd0, 16'($urandom_range(SHORT_SYMS)));
      end
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0:       return jhbr_pkg::MARKER_BYTE;
         1:       return 8'h00;
         2:       return jhbr_pkg::RST_LO + 8'($urandom_range(7));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic drain();
      int unsigned guard;
      go_quiet();
      guard = 0;
      while (decode_sb.pending_results.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic random_part(int unsigned n);
      jhbr_pkg::req_type q;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(19))
            0: begin
               // noise load, includes out-of-range targets and slots
               q = jhbr_pkg::req_type'($bits(jhbr_pkg::req_type)'({$urandom, $urandom}));
               q.mode = jhbr_pkg::MODE_LOAD;
               if (q.load_target <= jhbr_pkg::TGT_SYM)
                  q.load_index[7:4] = q.load_index[7:4] | 4'h1;
               if (q.load_target == jhbr_pkg::TGT_SYM ||
                   (q.load_target == jhbr_pkg::TGT_COUNT && q.table_id != 2'd0))
                  q.load_target = 3'd5;
               send_item(q);
            end
            1, 2: ask_raw($urandom_range(1) ? 5'($urandom_range(31)) : 5'($urandom_range(16)));
            3, 4, 5: ask_decode(2'($urandom_range(3)));
            default: stream_byte(pick_byte());
         endcase
      end
   endtask

   initial begin
      jhbr_pkg::req_type q;
      decode_sb = new();
      decode_sb.clear();
      item_count = 0;
      hold_rsp = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      req_valid = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: tables first, then the special cases
      load_tables(1'b0, 1'b1);
      q = '1;
      q.mode = jhbr_pkg::MODE_LOAD;
      send_item(q);                    // bad target, ignored
      ask_raw(5'd0);                   // zero-bit read
      ask_raw(5'd17);                  // too many bits
      ask_raw(5'd31);
      ask_raw(5'd16);                  // waits for bytes
      ask_decode(2'd1);                // request while busy
      stream_byte(8'hFF); stream_byte(8'h00);   // stuffed ff
      stream_byte(8'hFF); stream_byte(jhbr_pkg::RST_LO);  // restart
      stream_byte(8'hFF); stream_byte(jhbr_pkg::RST_HI);
      stream_byte(8'hA5);
      ask_decode(2'd3);
      stream_byte(8'h00); stream_byte(8'h00);
      ask_decode(2'd0);
      for (int i = 0; i < 6; i++) stream_byte(8'hFF); // marker then ff byte kept
      stream_byte(8'h5A);
      drain();
      // overflow: queue bytes with no request, then drain them
      for (int i = 0; i < 6; i++) stream_byte(8'($urandom_range(254)));
      ask_raw(5'd16); ask_raw(5'd16);
      drain();

      send_idle_pct = 27; recv_idle_pct = 49;
      random_part(RANDOM_ITEMS);
      drain();

      // long hold-off while the sender keeps going
      hold_rsp = 1;
      send_idle_pct = 49; recv_idle_pct = 27;
      load_tables(1'b1, 1'b0);
      random_part(RANDOM_ITEMS);
      drain();

      send_idle_pct = 0; recv_idle_pct = 0;
      random_part(RANDOM_ITEMS);
      drain();

      $display("covered %0d request transfers and %0d result transfers",
               item_count, decode_sb.result_count);
      if (decode_sb.mismatch_count == 0 && decode_sb.pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d results never seen",
                  decode_sb.mismatch_count, decode_sb.pending_results.size());
         $display("simulation failed");
      end
      $finish;
   end

endmodule
